// File: rtl/bbpi_pkg.sv
// Shared constants for the balanced block partition index.
`timescale 1ns / 1ps
package bbpi_pkg;

   localparam int OPERAND_WIDTH  = 32;
   localparam int RESULT_WIDTH   = 32;
   localparam int CSR_ADDR_WIDTH = 2;

   localparam logic [CSR_ADDR_WIDTH-1:0] CSR_RANGE_SIZE   = 2'd0;
   localparam logic [CSR_ADDR_WIDTH-1:0] CSR_WORKER_COUNT = 2'd1;

   localparam logic ACT_SIZE   = 1'b0;
   localparam logic ACT_LOCATE = 1'b1;

endpackage

// File: rtl/balanced_block_partition_index.sv
// Top level of the balanced block partition index.
// How to use:
//   A range of csr register 0 (range size) elements is split over csr register 1
//   (worker count) workers; the first range mod workers workers get one extra.
//   Write a register with csr_we, csr_addr and csr_wdata; only while idle.
//   After each write the chunk and remainder are recomputed bit-serially
//   while req_full stays high; no clearing pass at reset.
//   Request channel: push a transaction (req_action, req_operand) when
//   req_full is low. Action 0 asks a worker's offset and count, action 1
//   locates a global index (owning worker, local index).
//   Response channel: while rsp_empty is low the oldest result is shown;
//   rsp_pop takes it. rsp_error flags an operand out of range or a zero worker count, values zero.
//   Throughput is one transaction per cycle while req_full stays low; a
//   result passes the front item stages, the middle queue, the
//   one-bit-per-stage divider pipeline and the response queue until rsp_empty falls.
//   When the receiver stalls the response queue fills, the divider holds,
//   the middle queue fills and req_full rises. Reset restores range size 0
//   and worker count 1 and empties every queue.
`timescale 1ns / 1ps
module balanced_block_partition_index #(
   parameter int INDEX_WIDTH  = 32,
   parameter int WORKER_WIDTH = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [bbpi_pkg::CSR_ADDR_WIDTH-1:0] csr_addr,
   input  logic [((INDEX_WIDTH > WORKER_WIDTH) ? INDEX_WIDTH : WORKER_WIDTH)-1:0] csr_wdata,
   input  logic                                req_push,
   output logic                                req_full,
   input  logic                                req_action,
   input  logic [bbpi_pkg::OPERAND_WIDTH-1:0]  req_operand,
   output logic                                rsp_empty,
   input  logic                                rsp_pop,
   output logic [bbpi_pkg::RESULT_WIDTH-1:0]   rsp_first_value,
   output logic [bbpi_pkg::RESULT_WIDTH-1:0]   rsp_second_value,
   output logic                                rsp_error
);
   import bbpi_pkg::*;

   // working width covers the range size and the worker count
   localparam int DW = (INDEX_WIDTH > WORKER_WIDTH) ? INDEX_WIDTH : WORKER_WIDTH;
   localparam int XW = (INDEX_WIDTH > OPERAND_WIDTH) ? INDEX_WIDTH : OPERAND_WIDTH;
   localparam int EW = 2 + 5 * XW;
   localparam int RW = 2 * RESULT_WIDTH + 1;

   logic          q_full, q_push, q_empty, q_pop;
   logic [EW-1:0] q_wdata, q_rdata;
   logic          out_full, out_push;
   logic [RW-1:0] out_wdata, out_rdata;

   // front: take transactions and classify them
   bbpi_front #(
      .IW (INDEX_WIDTH),
      .WW (WORKER_WIDTH),
      .XW (XW),
      .DW (DW),
      .EW (EW)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_addr    (csr_addr),
      .csr_wdata   (csr_wdata),
      .req_push    (req_push),
      .req_action  (req_action),
      .req_operand (req_operand),
      .req_full    (req_full),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_data      (q_wdata)
   );

   // decouple front and back
   bbpi_fifo #(
      .WIDTH (EW),
      .DEPTH (4)
   ) u_mid_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wdata),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_rdata),
      .empty     (q_empty)
   );

   // back: divide and assemble results
   bbpi_back #(
      .XW (XW),
      .EW (EW),
      .RW (RW)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_empty  (q_empty),
      .q_data   (q_rdata),
      .q_pop    (q_pop),
      .out_full (out_full),
      .out_push (out_push),
      .out_data (out_wdata)
   );

   // hold finished results for the receiver
   bbpi_fifo #(
      .WIDTH (RW),
      .DEPTH (2)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_data (out_wdata),
      .full      (out_full),
      .pop       (rsp_pop),
      .pop_data  (out_rdata),
      .empty     (rsp_empty)
   );

   assign rsp_first_value  = out_rdata[RW-1 -: RESULT_WIDTH];
   assign rsp_second_value = out_rdata[RESULT_WIDTH:1];
   assign rsp_error        = out_rdata[0];

endmodule

// File: rtl/bbpi_fifo.sv
// Small register-based first-in first-out queue.
`timescale 1ns / 1ps
module bbpi_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);
   localparam int AW = $clog2(DEPTH);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW:0]      wr_ptr_ff, wr_ptr_in;
   logic [AW:0]      rd_ptr_ff, rd_ptr_in;
   logic             do_push, do_pop;

   assign empty    = (wr_ptr_ff == rd_ptr_ff);
   assign full     = (wr_ptr_ff[AW-1:0] == rd_ptr_ff[AW-1:0]) && (wr_ptr_ff[AW] != rd_ptr_ff[AW]);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff[AW-1:0]];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff[AW-1:0]] <= push_data;
      end
   end

   // occupancy never exceeds the depth
   a_occupancy: assert property (@(posedge clock) disable iff (reset)
      (wr_ptr_ff - rd_ptr_ff) <= (AW+1)'(DEPTH))
      else $error("fifo occupancy above depth");

endmodule

// File: rtl/bbpi_front.sv
// Front part: configuration, chunk division and query classification.
`timescale 1ns / 1ps
module bbpi_front #(
   parameter int IW = 32,
   parameter int WW = 16,
   parameter int XW = 32,
   parameter int DW = 32,
   parameter int EW = 162
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [bbpi_pkg::CSR_ADDR_WIDTH-1:0] csr_addr,
   input  logic [DW-1:0]                       csr_wdata,
   input  logic                                req_push,
   input  logic                                req_action,
   input  logic [bbpi_pkg::OPERAND_WIDTH-1:0]  req_operand,
   output logic                                req_full,
   input  logic                                q_full,
   output logic                                q_push,
   output logic [EW-1:0]                       q_data
);
   import bbpi_pkg::*;

   typedef struct packed {
      logic          err;
      logic          locate;
      logic [XW-1:0] dividend;
      logic [XW-1:0] divisor;
      logic [XW-1:0] base;
      logic [XW-1:0] direct_first;
      logic [XW-1:0] direct_second;
   } entry_type;

   localparam int CW = $clog2(IW+1);
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_LOAD = 2'd1;
   localparam logic [1:0] ST_DIV  = 2'd2;
   localparam logic [1:0] ST_MUL  = 2'd3;

   logic [IW-1:0] range_ff, range_in;
   logic [WW-1:0] workers_ff, workers_in;
   logic [1:0]    state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [IW-1:0] dq_ff, dq_in;
   logic [WW-1:0] dr_ff, dr_in;
   logic [XW-1:0] chunk_ff, chunk_in;
   logic [WW-1:0] rem_ff, rem_in;
   logic [XW-1:0] split_ff, split_in;
   logic [WW:0]   trial;
   logic          fits;
   logic [XW-1:0] big;
   logic [XW+WW-1:0] split_prod;

   always_comb begin
      trial = {dr_ff, dq_ff[IW-1]};
      fits  = trial >= {1'b0, workers_ff};
      big   = XW'(dq_ff) + 1'b1;
      split_prod = {{WW{1'b0}}, big} * {{XW{1'b0}}, dr_ff};
   end

   always_comb begin
      range_in   = range_ff;
      workers_in = workers_ff;
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      dq_in      = dq_ff;
      dr_in      = dr_ff;
      chunk_in   = chunk_ff;
      rem_in     = rem_ff;
      split_in   = split_ff;
      case (state_ff)
         ST_LOAD: begin
            dq_in    = range_ff;
            dr_in    = '0;
            cnt_in   = CW'(IW);
            state_in = ST_DIV;
         end
         ST_DIV: begin
            dq_in  = {dq_ff[IW-2:0], fits};
            dr_in  = fits ? WW'(trial - {1'b0, workers_ff}) : trial[WW-1:0];
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == CW'(1)) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            chunk_in = XW'(dq_ff);
            rem_in   = dr_ff;
            split_in = split_prod[XW-1:0];
            state_in = ST_IDLE;
         end
         default: begin
         end
      endcase
      if (csr_we) begin
         if (csr_addr == CSR_RANGE_SIZE) begin
            range_in = csr_wdata[IW-1:0];
            state_in = ST_LOAD;
         end else if (csr_addr == CSR_WORKER_COUNT) begin
            workers_in = csr_wdata[WW-1:0];
            state_in   = ST_LOAD;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         range_ff   <= '0;
         workers_ff <= WW'(1);
         state_ff   <= ST_IDLE;
         cnt_ff     <= '0;
         chunk_ff   <= '0;
         rem_ff     <= '0;
         split_ff   <= '0;
      end else begin
         range_ff   <= range_in;
         workers_ff <= workers_in;
         state_ff   <= state_in;
         cnt_ff     <= cnt_in;
         chunk_ff   <= chunk_in;
         rem_ff     <= rem_in;
         split_ff   <= split_in;
      end
   end

   always_ff @(posedge clock) begin
      dq_ff <= dq_in;
      dr_ff <= dr_in;
   end

   // item stages
   logic                     s1_v_ff, s1_v_in, s2_v_ff, s2_v_in;
   logic                     s1_action_ff;
   logic [OPERAND_WIDTH-1:0] s1_operand_ff;
   logic                     s2_adv, s1_adv, take;
   logic [XW-1:0]            opx;
   logic [XW+WW-1:0]         mprod;
   entry_type                s2_ff, s2_in;
   logic [XW-1:0]            s2_lower_ff, s2_lower_in;
   entry_type                ent;

   assign s2_adv   = !s2_v_ff || !q_full;
   assign s1_adv   = !s1_v_ff || s2_adv;
   assign req_full = (state_ff != ST_IDLE) || !s1_adv;
   assign take     = req_push && !req_full;
   assign q_push   = s2_v_ff && !q_full;

   always_comb begin
      s1_v_in = take ? 1'b1 : (s2_adv ? 1'b0 : s1_v_ff);
      s2_v_in = s2_adv ? s1_v_ff : s2_v_ff;
   end

   always_comb begin
      opx   = XW'(s1_operand_ff);
      mprod = {{WW{1'b0}}, chunk_ff} * {{XW{1'b0}}, opx[WW-1:0]};
      s2_in = '0;
      s2_in.locate        = (s1_action_ff == ACT_LOCATE);
      s2_in.direct_first  = mprod[XW-1:0];
      s2_in.direct_second = chunk_ff + XW'(opx < XW'(rem_ff));
      s2_lower_in         = (opx < XW'(rem_ff)) ? opx : XW'(rem_ff);
      if (opx < split_ff) begin
         s2_in.dividend = opx;
         s2_in.divisor  = chunk_ff + 1'b1;
         s2_in.base     = '0;
      end else begin
         s2_in.dividend = opx - split_ff;
         s2_in.divisor  = chunk_ff;
         s2_in.base     = XW'(rem_ff);
      end
      if (workers_ff == '0) begin
         s2_in.err = 1'b1;
      end else if (s1_action_ff == ACT_SIZE) begin
         s2_in.err = opx >= XW'(workers_ff);
      end else begin
         s2_in.err = (opx >= XW'(range_ff)) || ((opx >= split_ff) && (chunk_ff == '0));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= s1_v_in;
         s2_v_ff <= s2_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         s1_action_ff  <= req_action;
         s1_operand_ff <= req_operand;
      end
      if (s2_adv) begin
         s2_ff       <= s2_in;
         s2_lower_ff <= s2_lower_in;
      end
   end

   always_comb begin
      ent              = s2_ff;
      ent.direct_first = s2_ff.direct_first + s2_lower_ff;
   end
   assign q_data = ent;

   a_cfg_blocks: assert property (@(posedge clock) disable iff (reset)
      csr_we |=> req_full)
      else $error("input open right after a register write");

   a_no_zero_div: assert property (@(posedge clock) disable iff (reset)
      (q_push && ent.locate && !ent.err) |-> (ent.divisor != '0))
      else $error("zero divisor sent to divider");

endmodule

// File: rtl/bbpi_back.sv
// Back part: pipelined divider and result assembly.
`timescale 1ns / 1ps
module bbpi_back #(
   parameter int XW = 32,
   parameter int EW = 162,
   parameter int RW = 65
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          q_empty,
   input  logic [EW-1:0] q_data,
   output logic          q_pop,
   input  logic          out_full,
   output logic          out_push,
   output logic [RW-1:0] out_data
);
   import bbpi_pkg::*;

   typedef struct packed {
      logic          err;
      logic          locate;
      logic [XW-1:0] dividend;
      logic [XW-1:0] divisor;
      logic [XW-1:0] base;
      logic [XW-1:0] direct_first;
      logic [XW-1:0] direct_second;
   } entry_type;

   logic          adv;
   logic          v_w   [0:XW];
   entry_type     ent_w [0:XW];
   logic [XW-1:0] n_w   [0:XW];
   logic [XW-1:0] r_w   [0:XW];
   logic          v_ff   [1:XW];
   entry_type     ent_ff [1:XW];
   logic [XW-1:0] n_ff   [1:XW];
   logic [XW-1:0] r_ff   [1:XW];

   assign adv   = !out_full;
   assign q_pop = adv && !q_empty;

   assign v_w[0]   = !q_empty;
   assign ent_w[0] = q_data;
   assign n_w[0]   = ent_w[0].dividend;
   assign r_w[0]   = '0;

   for (genvar i = 0; i < XW; i++) begin : g_stage
      logic [XW:0]   trial;
      logic          fits;
      logic [XW-1:0] n_in, r_in;

      always_comb begin
         trial = {r_w[i], n_w[i][XW-1]};
         fits  = trial >= {1'b0, ent_w[i].divisor};
         r_in  = fits ? XW'(trial - {1'b0, ent_w[i].divisor}) : trial[XW-1:0];
         n_in  = {n_w[i][XW-2:0], fits};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i+1] <= 1'b0;
         end else if (adv) begin
            v_ff[i+1] <= v_w[i];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            ent_ff[i+1] <= ent_w[i];
            n_ff[i+1]   <= n_in;
            r_ff[i+1]   <= r_in;
         end
      end

      assign v_w[i+1]   = v_ff[i+1];
      assign ent_w[i+1] = ent_ff[i+1];
      assign n_w[i+1]   = n_ff[i+1];
      assign r_w[i+1]   = r_ff[i+1];
   end

   logic [XW-1:0]           fin_first, fin_second;
   logic [RESULT_WIDTH-1:0] res_first, res_second;

   always_comb begin
      fin_first  = ent_w[XW].locate ? n_w[XW] + ent_w[XW].base : ent_w[XW].direct_first;
      fin_second = ent_w[XW].locate ? r_w[XW] : ent_w[XW].direct_second;
      res_first  = ent_w[XW].err ? '0 : fin_first[RESULT_WIDTH-1:0];
      res_second = ent_w[XW].err ? '0 : fin_second[RESULT_WIDTH-1:0];
   end

   assign out_push = v_w[XW] && adv;
   assign out_data = {res_first, res_second, ent_w[XW].err};

   a_rem_below: assert property (@(posedge clock) disable iff (reset)
      (v_w[XW] && ent_w[XW].locate && !ent_w[XW].err) |-> (r_w[XW] < ent_w[XW].divisor))
      else $error("divider remainder not below divisor");

endmodule
